// ===== hdl/mlrq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared constants of the multilevel ready queue: operation codes and
// default sizes.
// ----------------------------------------------------------------------------
package mlrq_pkg;

    localparam int LEVELS_DEF = 4;
    localparam int PROCS_DEF  = 16;

    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_ENQ  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 3'd1;
    localparam logic [OP_W-1:0] OP_REM  = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd3;
    localparam logic [OP_W-1:0] OP_MEMB = 3'd4;

endpackage

// ===== hdl/mlrq_if.sv =====
// ----------------------------------------------------------------------------
// mlrq_req_if / mlrq_rsp_if
// Valid/ready channels of the ready queue: one command beat in, one result
// beat out.
// ----------------------------------------------------------------------------
interface mlrq_req_if
    import mlrq_pkg::*;
#(
    parameter int ID_W  = 4,
    parameter int LVL_W = 2
) ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ID_W-1:0]  proc_id;
    logic [LVL_W-1:0] level;

    modport source (output valid, operation, proc_id, level, input ready);
    modport sink   (input valid, operation, proc_id, level, output ready);
endinterface

interface mlrq_rsp_if
    import mlrq_pkg::*;
#(
    parameter int ID_W  = 4,
    parameter int TOP_W = 3
) ();
    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  out_id;
    logic             found;
    logic [TOP_W-1:0] top_level;

    modport source (output valid, out_id, found, top_level, input ready);
    modport sink   (input valid, out_id, found, top_level, output ready);
endinterface

// ===== hdl/multilevel_ready_queue.sv =====
// ----------------------------------------------------------------------------
// multilevel_ready_queue
// One linked FIFO of process ids per priority level: enqueue, dequeue
// highest, remove, peek and membership, each answered by one result beat.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          beat
//  req      in   operation, proc_id, level        one command
//  rsp      out  out_id, found, top_level         one result per command
//
//  One command is in work at a time. Peek and membership go from the idle
//  state to the done state, which registers the result; enqueue reads a
//  non-empty level first; dequeue reads the best level and pops its head
//  unless every level is empty; remove, if its level is non-empty and the
//  process is queued, reads that level and walks the list, one read of the
//  link memory per hop (fewer than PROCS hops). No clearing pass after
//  reset. A stalled result holds the output register; the next command is
//  still taken and waits for that register before it posts its own result.
// ----------------------------------------------------------------------------
module multilevel_ready_queue
    import mlrq_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF,
    parameter int PROCS  = PROCS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mlrq_req_if.sink   req,
    mlrq_rsp_if.source rsp
);

    localparam int ID_W  = $clog2(PROCS);
    localparam int LVL_W = $clog2(LEVELS);
    localparam int TOP_W = $clog2(LEVELS + 1);
    localparam int LR_W  = 2 * ID_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LVL    = 3'd1;
    localparam logic [2:0] ST_POP    = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_SPLICE = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ID_W-1:0]   pid_reg, pid_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [ID_W-1:0]   head_reg, head_next;
    logic [ID_W-1:0]   tail_reg, tail_next;
    logic [ID_W-1:0]   prev_reg, prev_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic              found_reg, found_next;
    logic [LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [PROCS-1:0]  queued_reg, queued_next;
    logic [PROCS-1:0]  link_valid_reg, link_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic              out_found_reg, out_found_next;
    logic [TOP_W-1:0]  out_top_reg, out_top_next;

    logic              link_we;
    logic [ID_W-1:0]   link_waddr, link_wdata, link_raddr, link_rdata;
    logic              lvl_we;
    logic [LVL_W-1:0]  lvl_waddr, lvl_raddr;
    logic [LR_W-1:0]   lvl_wdata, lvl_rdata;
    logic [ID_W-1:0]   rd_head, rd_tail;

    logic [TOP_W-1:0]  best;
    logic [LVL_W-1:0]  best_idx;
    logic              in_pid_ok, in_lvl_ok, in_ok;

    mlrq_ram #(.WIDTH(ID_W), .DEPTH(PROCS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mlrq_ram #(.WIDTH(LR_W), .DEPTH(LEVELS)) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    assign rd_head = lvl_rdata[LR_W-1:ID_W];
    assign rd_tail = lvl_rdata[ID_W-1:0];

    // lowest non-empty level, LEVELS when all are empty
    always_comb
    begin
        best = TOP_W'(LEVELS);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                best = TOP_W'(i);
            end
        end
    end

    assign best_idx  = LVL_W'(best);
    assign in_pid_ok = {1'b0, req.proc_id} < (ID_W + 1)'(PROCS);
    assign in_lvl_ok = {1'b0, req.level} < (LVL_W + 1)'(LEVELS);
    assign in_ok     = in_pid_ok && in_lvl_ok;

    assign lvl_raddr = (req.operation == OP_DEQ) ? best_idx : req.level;
    // follow the list: head on the first hop, then the link just read
    assign link_raddr = (state_reg == ST_LVL) ? rd_head :
                        (link_rdata == pid_reg) ? pid_reg : link_rdata;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        pid_next        = pid_reg;
        lvl_next        = lvl_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        prev_next       = prev_reg;
        id_next         = id_reg;
        found_next      = found_reg;
        nonempty_next   = nonempty_reg;
        queued_next     = queued_reg;
        link_valid_next = link_valid_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_id_next     = out_id_reg;
        out_found_next  = out_found_reg;
        out_top_next    = out_top_reg;
        link_we         = 1'b0;
        link_waddr      = prev_reg;
        link_wdata      = link_rdata;
        lvl_we          = 1'b0;
        lvl_waddr       = lvl_reg;
        lvl_wdata       = {head_reg, tail_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    pid_next   = req.proc_id;
                    lvl_next   = req.level;
                    id_next    = '0;
                    found_next = 1'b0;
                    state_next = ST_DONE;
                    case (req.operation)
                        OP_ENQ:
                        begin
                            if (in_ok && !queued_reg[req.proc_id])
                            begin
                                if (nonempty_reg[req.level])
                                begin
                                    state_next = ST_LVL;
                                end
                                else
                                begin
                                    lvl_we        = 1'b1;
                                    lvl_waddr     = req.level;
                                    lvl_wdata     = {req.proc_id, req.proc_id};
                                    nonempty_next[req.level]     = 1'b1;
                                    queued_next[req.proc_id]     = 1'b1;
                                    link_valid_next[req.proc_id] = 1'b0;
                                end
                            end
                        end
                        OP_DEQ:
                        begin
                            if (|nonempty_reg)
                            begin
                                lvl_next   = best_idx;
                                state_next = ST_LVL;
                            end
                        end
                        OP_REM:
                        begin
                            if (in_ok && nonempty_reg[req.level] &&
                                queued_reg[req.proc_id])
                            begin
                                state_next = ST_LVL;
                            end
                        end
                        OP_MEMB:
                        begin
                            found_next = in_pid_ok && queued_reg[req.proc_id];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_LVL:
            begin
                head_next  = rd_head;
                tail_next  = rd_tail;
                prev_next  = rd_head;
                state_next = ST_DONE;
                if (op_reg == OP_ENQ)
                begin
                    // append behind the current tail
                    link_we    = 1'b1;
                    link_waddr = rd_tail;
                    link_wdata = pid_reg;
                    lvl_we     = 1'b1;
                    lvl_wdata  = {rd_head, pid_reg};
                    link_valid_next[rd_tail] = 1'b1;
                    link_valid_next[pid_reg] = 1'b0;
                    queued_next[pid_reg]     = 1'b1;
                end
                else if (op_reg == OP_DEQ || rd_head == pid_reg)
                begin
                    if (op_reg == OP_DEQ)
                    begin
                        id_next    = rd_head;
                        found_next = 1'b1;
                    end
                    if (link_valid_reg[rd_head])
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        nonempty_next[lvl_reg]   = 1'b0;
                        queued_next[rd_head]     = 1'b0;
                        link_valid_next[rd_head] = 1'b0;
                    end
                end
                else if (link_valid_reg[rd_head])
                begin
                    state_next = ST_WALK;
                end
            end

            ST_POP:
            begin
                lvl_we     = 1'b1;
                lvl_wdata  = {link_rdata, tail_reg};
                queued_next[head_reg]     = 1'b0;
                link_valid_next[head_reg] = 1'b0;
                state_next = ST_DONE;
            end

            ST_WALK:
            begin
                if (link_rdata == pid_reg)
                begin
                    if (link_valid_reg[pid_reg])
                    begin
                        state_next = ST_SPLICE;
                    end
                    else
                    begin
                        // drop the tail: predecessor becomes the new tail
                        lvl_we     = 1'b1;
                        lvl_wdata  = {head_reg, prev_reg};
                        link_valid_next[prev_reg] = 1'b0;
                        queued_next[pid_reg]      = 1'b0;
                        link_valid_next[pid_reg]  = 1'b0;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    prev_next = link_rdata;
                    if (!link_valid_reg[link_rdata])
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SPLICE:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_rdata;
                queued_next[pid_reg]     = 1'b0;
                link_valid_next[pid_reg] = 1'b0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = id_reg;
                    out_found_next = found_reg;
                    out_top_next   = best;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nonempty_reg   <= '0;
            queued_reg     <= '0;
            link_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nonempty_reg   <= nonempty_next;
            queued_reg     <= queued_next;
            link_valid_reg <= link_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pid_reg       <= pid_next;
        lvl_reg       <= lvl_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        prev_reg      <= prev_next;
        id_reg        <= id_next;
        found_reg     <= found_next;
        out_id_reg    <= out_id_next;
        out_found_reg <= out_found_next;
        out_top_reg   <= out_top_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_id    = out_id_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.top_level = out_top_reg;

    a_link_implies_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (link_valid_reg & ~queued_reg) == '0)
        else $error("link valid on a process that is not queued");

    a_empty_levels_no_procs: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg == '0) |-> (queued_reg == '0))
        else $error("process queued while every level is empty");

    a_one_tail_per_level: assert property (@(posedge clk) disable iff (!rst_n)
        (queued_reg != '0) |-> ($countones(link_valid_reg) < $countones(queued_reg)))
        else $error("queued lists lost their tail");

    a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !rsp.ready) |=> (state_reg == ST_DONE))
        else $error("result posted over an unaccepted beat");

endmodule

// ===== hdl/mlrq_ram.sv =====
// ----------------------------------------------------------------------------
// mlrq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlrq_ram
    import mlrq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
